### rtl/slrl_pkg.sv
// Shared types and constants for the sliding log rate limiter.
// Used by slrl_ctrl, slrl_dp and the top level; no dependencies.
package slrl_pkg;

  localparam int NUM_CLIENTS_DEF   = 16;
  localparam int MAX_IN_WINDOW_DEF = 3;
  localparam logic [30:0] WINDOW_RESET = 31'd1000;

  typedef enum logic [2:0] {
    ST_ALLOWED    = 3'd0,
    ST_DENIED     = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_REGISTERED = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // latch the request, restart the table scan
    logic scan;    // issue one table read, compare the previous one
    logic act;     // register, append, or fetch the oldest stamp
    logic chk;     // window check on a full log
    logic fin;     // load the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic need_chk;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/slrl_ctrl.sv
// Controller state machine of the sliding log rate limiter.
// Depends on slrl_pkg for the command and status structs.
module slrl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slrl_pkg::dp_stat_t   stat,
  output slrl_pkg::ctrl_cmd_t  cmd
);
  import slrl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_ACT  = 5'b00100,
    S_CHK  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (stat.scan_done) state_next = S_ACT;
      S_ACT:  state_next = stat.need_chk ? S_CHK : S_FIN;
      S_CHK:  state_next = S_FIN;
      S_FIN:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign cmd.start = (state == S_IDLE) && in_valid;
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.act   = (state == S_ACT);
  assign cmd.chk   = (state == S_CHK);
  assign cmd.fin   = (state == S_FIN) && stat.out_free;

  a_chk_after_act: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> $past(state) == S_ACT)
    else $error("window check entered without a decision cycle");

endmodule

### rtl/slrl_dp.sv
// Datapath of the sliding log rate limiter: client table, stamp log,
// per-client log counters, window register and output register. Uses slrl_pkg.
module slrl_dp #(
  parameter int NUM_CLIENTS   = slrl_pkg::NUM_CLIENTS_DEF,
  parameter int MAX_IN_WINDOW = slrl_pkg::MAX_IN_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  slrl_pkg::ctrl_cmd_t  cmd,
  output slrl_pkg::dp_stat_t   stat,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_data,
  input  logic                 func,
  input  logic signed [31:0]   client_id,
  input  logic signed [31:0]   request_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic                 allowed
);
  import slrl_pkg::*;

  localparam int IW    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CW    = $clog2(MAX_IN_WINDOW + 1);
  localparam int HW    = (MAX_IN_WINDOW > 1) ? $clog2(MAX_IN_WINDOW) : 1;
  localparam int DEPTH = NUM_CLIENTS * MAX_IN_WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CLIENTS - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_IN_WINDOW);
  localparam logic [HW-1:0] LAST_POS = HW'(MAX_IN_WINDOW - 1);

  logic [30:0] window;

  logic        key_func;
  logic [31:0] key_id;
  logic [31:0] key_time;

  logic [31:0] id_mem [NUM_CLIENTS];
  logic [31:0] stamp_mem [DEPTH];
  logic [31:0] id_rd;
  logic [31:0] st_rd;

  logic [NUM_CLIENTS-1:0] entry_valid;
  logic [CW-1:0] log_count [NUM_CLIENTS];
  logic [HW-1:0] log_head [NUM_CLIENTS];

  logic [IW-1:0] scan_idx, cmp_idx, found_idx, free_idx;
  logic          iss_vld, cmp_vld, found, free_found;
  logic          match;

  logic [CW-1:0] cnt_rd;
  logic [HW-1:0] head_rd, head_inc;
  logic [AW-1:0] base, app_addr, old_addr, st_waddr;
  logic [CW:0]   pos_sum, pos;
  logic [31:0]   diff;
  logic          deny, reg_wr, app_wr, rep_wr, st_we;
  status_t       res, act_code;

  // window register
  always_ff @(posedge clk) begin
    if (rst)         window <= WINDOW_RESET;
    else if (cfg_we) window <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_func <= func;
      key_id   <= client_id;
      key_time <= request_time;
    end
  end

  // table scan: the compare works on the ID read at the previous scan address
  assign match = cmp_vld && entry_valid[cmp_idx] && (id_rd == key_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_vld    <= 1'b0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_idx   <= '0;
    end else if (cmd.start) begin
      iss_vld    <= 1'b1;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_idx   <= '0;
    end else if (cmd.scan) begin
      cmp_vld <= iss_vld;
      if (iss_vld) begin
        if (scan_idx == LAST_IDX) iss_vld <= 1'b0;
        else                      scan_idx <= scan_idx + 1'b1;
        if (!entry_valid[scan_idx] && !free_found) free_found <= 1'b1;
      end
      if (match) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx;
      if (iss_vld && !entry_valid[scan_idx] && !free_found) free_idx <= scan_idx;
      if (match) found_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_wr) id_mem[free_idx] <= key_id;
    id_rd <= id_mem[scan_idx];
  end

  // log addressing for the matched client
  assign cnt_rd   = log_count[found_idx];
  assign head_rd  = log_head[found_idx];
  assign head_inc = (head_rd == LAST_POS) ? '0 : head_rd + 1'b1;
  assign base     = AW'(found_idx) * AW'(MAX_IN_WINDOW);
  assign pos_sum  = (CW+1)'(head_rd) + (CW+1)'(cnt_rd);
  assign pos      = (pos_sum >= (CW+1)'(MAX_IN_WINDOW)) ?
                    pos_sum - (CW+1)'(MAX_IN_WINDOW) : pos_sum;
  assign app_addr = base + AW'(pos);
  assign old_addr = base + AW'(head_rd);

  assign diff   = key_time - st_rd;
  assign deny   = diff[31] || (diff[30:0] < window);

  assign reg_wr   = cmd.act && !key_func && !found && free_found;
  assign app_wr   = cmd.act && key_func && found && (cnt_rd < MAX_CNT);
  assign rep_wr   = cmd.chk && !deny;
  assign st_we    = app_wr || rep_wr;
  assign st_waddr = app_wr ? app_addr : old_addr;

  // oldest stamp is read every cycle; it is settled by the window check
  always_ff @(posedge clk) begin
    if (st_we) stamp_mem[st_waddr] <= key_time;
    st_rd <= stamp_mem[old_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        log_count[k] <= '0;
        log_head[k]  <= '0;
      end
    end else begin
      if (reg_wr) begin
        entry_valid[free_idx] <= 1'b1;
        log_count[free_idx]   <= '0;
        log_head[free_idx]    <= '0;
      end
      if (app_wr) log_count[found_idx] <= cnt_rd + 1'b1;
      if (rep_wr) log_head[found_idx]  <= head_inc;
    end
  end

  always_comb begin
    if (!key_func) begin
      if (found)           act_code = ST_DUPLICATE;
      else if (free_found) act_code = ST_REGISTERED;
      else                 act_code = ST_FULL;
    end else begin
      if (!found)          act_code = ST_UNKNOWN;
      else                 act_code = ST_ALLOWED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act)      res <= act_code;
    else if (cmd.chk) res <= deny ? ST_DENIED : ST_ALLOWED;
  end

  // output register: take the next result in the cycle the current one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status  <= res;
      allowed <= (res == ST_ALLOWED);
    end
  end

  assign stat.scan_done = cmp_vld && (match || (cmp_idx == LAST_IDX));
  assign stat.need_chk  = key_func && found && (cnt_rd == MAX_CNT);
  assign stat.out_free  = !out_valid || !out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    found |-> cnt_rd <= MAX_CNT)
    else $error("log count of a matched client exceeds the log depth");

endmodule

### rtl/per_client_sliding_log_rate_limiter.sv
// Top level of the per-client sliding log rate limiter.
// Instantiates slrl_ctrl and slrl_dp; uses slrl_pkg.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  func, client_id, request_time
//  out      output     out_valid/out_stall  status, allowed
//  cfg      input      cfg_we               cfg_data (window_ticks)
//
// After the accepting edge the request passes the client table scan, the decision state,
// the window check state when the client's log is full, and the output load, which waits
// for a free output register; out_valid then rises and the next request can be taken.
// A hit ends the scan early. The scan is one registered ID read a cycle.
// Reset clears the valid bits and log counters at once; no clearing pass.
// The next request is accepted while a result waits in the output register.
module per_client_sliding_log_rate_limiter #(
  parameter int NUM_CLIENTS   = slrl_pkg::NUM_CLIENTS_DEF,
  parameter int MAX_IN_WINDOW = slrl_pkg::MAX_IN_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic signed [31:0]  client_id,
  input  logic signed [31:0]  request_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic                allowed,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_data
);
  import slrl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  slrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  slrl_dp #(
    .NUM_CLIENTS   (NUM_CLIENTS),
    .MAX_IN_WINDOW (MAX_IN_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .func         (func),
    .client_id    (client_id),
    .request_time (request_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .allowed      (allowed)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while the first is in work");

  a_allowed_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> allowed == (status == ST_ALLOWED))
    else $error("allowed flag disagrees with status code");

endmodule

### bench/testbench.sv
// Self-checking bench for the per-client sliding log rate limiter.
// Predicts every result from a local model of the client table and stamp logs.
// Depends on slrl_pkg and per_client_sliding_log_rate_limiter.
`timescale 1ns / 1ps

module testbench;
  import slrl_pkg::*;

  localparam int   CLIENTS     = NUM_CLIENTS_DEF;
  localparam int   LOG_DEPTH   = MAX_IN_WINDOW_DEF;
  localparam int   STALL_LIMIT = 3000;
  localparam logic FN_REGISTER = 1'b0;
  localparam logic FN_REQUEST  = 1'b1;

  typedef struct {
    status_t status;
    logic    allowed;
  } verdict_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic               func         = FN_REGISTER;
  logic signed [31:0] client_id    = '0;
  logic signed [31:0] request_time = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [2:0]         status;
  logic               allowed;
  logic               cfg_we       = 1'b0;
  logic [30:0]        cfg_data     = '0;

  // local copy of the limiter state
  logic [31:0] ids_m    [CLIENTS];
  bit          used_m   [CLIENTS];
  logic [31:0] stamps_m [CLIENTS][LOG_DEPTH];
  int unsigned fill_m   [CLIENTS];
  int unsigned head_m   [CLIENTS];
  logic [31:0] last_m   [CLIENTS];
  logic [30:0] window_m = WINDOW_RESET;

  verdict_t pending_verdicts[$];
  int       mismatches   = 0;
  int       hold_cycles  = 0;
  int       burst_left   = 0;
  int       quiet_cycles = 0;
  bit       gaps_off     = 1'b0;
  bit       offer_live   = 1'b0;

  always #6 clk = ~clk;

  per_client_sliding_log_rate_limiter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .client_id    (client_id),
    .request_time (request_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .allowed      (allowed),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  function automatic int lookup_client(input logic [31:0] id);
    for (int k = 0; k < CLIENTS; k++) begin
      if (used_m[k] && ids_m[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic verdict_t predict_verdict(input logic fn, input logic [31:0] id,
                                               input logic [31:0] stamp);
    verdict_t    v;
    int          slot;
    int unsigned pos;
    logic [31:0] age;
    slot = lookup_client(id);
    if (fn == FN_REGISTER) begin
      if (slot >= 0) begin
        v.status = ST_DUPLICATE;
      end else begin
        for (int k = 0; k < CLIENTS; k++) begin
          if (!used_m[k] && slot < 0) slot = k;
        end
        if (slot < 0) begin
          v.status = ST_FULL;
        end else begin
          used_m[slot] = 1'b1;
          ids_m[slot]  = id;
          fill_m[slot] = 0;
          head_m[slot] = 0;
          v.status     = ST_REGISTERED;
        end
      end
    end else if (slot < 0) begin
      v.status = ST_UNKNOWN;
    end else if (fill_m[slot] < LOG_DEPTH) begin
      pos = (head_m[slot] + fill_m[slot]) % LOG_DEPTH;
      stamps_m[slot][pos] = stamp;
      fill_m[slot]++;
      last_m[slot] = stamp;
      v.status = ST_ALLOWED;
    end else begin
      // age of the oldest stamp, wrapped and read as signed
      age = stamp - stamps_m[slot][head_m[slot]];
      if (age[31] || age < {1'b0, window_m}) begin
        v.status = ST_DENIED;
      end else begin
        stamps_m[slot][head_m[slot]] = stamp;
        head_m[slot] = (head_m[slot] + 1) % LOG_DEPTH;
        last_m[slot] = stamp;
        v.status = ST_ALLOWED;
      end
    end
    v.allowed = (v.status == ST_ALLOWED);
    return v;
  endfunction

  task automatic quiet_source();
    if (offer_live) begin
      in_valid   <= 1'b0;
      offer_live = 1'b0;
    end
  endtask

  task automatic send_item(input logic fn, input logic [31:0] id, input logic [31:0] stamp);
    int gap;
    in_valid     <= 1'b1;
    func         <= fn;
    client_id    <= id;
    request_time <= stamp;
    do @(posedge clk); while (in_stall);
    offer_live = 1'b1;
    pending_verdicts.push_back(predict_verdict(fn, id, stamp));
    if (!gaps_off) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0) begin
          quiet_source();
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    quiet_source();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [30:0] ticks);
    wait_drained();
    // let a late lookup finish before touching the register
    repeat (CLIENTS + 8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we   <= 1'b0;
    window_m = ticks;
  endtask

  // one request just inside the window, one exactly at its edge; log must be full
  task automatic probe_window_edge(input logic [31:0] id);
    int          slot;
    logic [31:0] oldest;
    slot   = lookup_client(id);
    oldest = stamps_m[slot][head_m[slot]];
    send_item(FN_REQUEST, id, oldest + window_m - 1);
    send_item(FN_REQUEST, id, oldest + window_m);
  endtask

  task automatic send_random_item();
    int          pick;
    int          k;
    logic [31:0] base;
    logic [31:0] stamp;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, CLIENTS - 1);
    if (pick < 6) begin
      send_item(FN_REGISTER, $urandom(), $urandom());
    end else if (pick < 10) begin
      send_item(FN_REGISTER, ids_m[k], $urandom());
    end else if (pick < 18) begin
      send_item(FN_REQUEST, $urandom(), $urandom());
    end else begin
      base = (fill_m[k] == LOG_DEPTH) ? stamps_m[k][head_m[k]] : last_m[k];
      case ($urandom_range(0, 5))
        0:       stamp = $urandom();
        1, 2:    stamp = base + window_m + $urandom_range(0, 6) - 3;
        3:       stamp = base - $urandom_range(1, 100);
        default: stamp = last_m[k] + $urandom_range(0, window_m / 2);
      endcase
      send_item(FN_REQUEST, ids_m[k], stamp);
    end
  endtask

  task automatic test_registration_and_admission();
    send_item(FN_REQUEST, 32'd0, 32'd0);
    send_item(FN_REGISTER, 32'h8000_0000, $urandom());
    send_item(FN_REGISTER, 32'h7fff_ffff, $urandom());
    send_item(FN_REGISTER, 32'd0, $urandom());
    send_item(FN_REGISTER, 32'hffff_ffff, $urandom());
    send_item(FN_REGISTER, 32'd0, $urandom());
    send_item(FN_REQUEST, 32'h8000_0000, 32'd100);
    send_item(FN_REQUEST, 32'h8000_0000, 32'd200);
    send_item(FN_REQUEST, 32'h8000_0000, 32'd300);
    send_item(FN_REQUEST, 32'h8000_0000, 32'd1099);
    send_item(FN_REQUEST, 32'h8000_0000, 32'd1100);
    send_item(FN_REQUEST, 32'h8000_0000, 32'd50);
    send_item(FN_REQUEST, 32'h8000_0000, 32'h7fff_ffff);
    send_item(FN_REQUEST, 32'h8000_0000, 32'h8000_0000);
    // stamps that straddle the signed wrap point
    send_item(FN_REQUEST, 32'h7fff_ffff, 32'h7fff_ff00);
    send_item(FN_REQUEST, 32'h7fff_ffff, 32'h7fff_ff10);
    send_item(FN_REQUEST, 32'h7fff_ffff, 32'h7fff_ff20);
    send_item(FN_REQUEST, 32'h7fff_ffff, 32'h8000_0300);
    send_item(FN_REQUEST, 32'd12345, $urandom());
  endtask

  task automatic test_window_bounds();
    write_window(31'd1);
    repeat (LOG_DEPTH) send_item(FN_REQUEST, 32'd0, 32'd5);
    probe_window_edge(32'd0);
    write_window(31'h7fff_ffff);
    repeat (LOG_DEPTH) send_item(FN_REQUEST, 32'hffff_ffff, 32'hffff_fff0);
    probe_window_edge(32'hffff_ffff);
    write_window(WINDOW_RESET);
    probe_window_edge(32'h8000_0000);
  endtask

  task automatic test_table_full();
    int taken;
    do begin
      taken = 0;
      foreach (used_m[k]) taken += used_m[k];
      if (taken < CLIENTS) send_item(FN_REGISTER, $urandom(), $urandom());
    end while (taken < CLIENTS);
    send_item(FN_REGISTER, 32'h1234_5678, $urandom());
    send_item(FN_REGISTER, 32'h8000_0000, $urandom());
    send_item(FN_REQUEST, 32'h1234_5678, $urandom());
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 400;
    gaps_off    = 1'b1;
    repeat (40) send_random_item();
    gaps_off    = 1'b0;
  endtask

  task automatic test_drain_then_send();
    repeat (6) send_random_item();
    wait_drained();
    repeat (6) send_random_item();
  endtask

  task automatic test_random_traffic();
    logic [30:0] ticks;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       ticks = 31'd1;
        1:       ticks = $urandom_range(2, 5000);
        2:       ticks = 31'h7fff_ffff;
        3:       ticks = $urandom_range(32'h0010_0000, 32'h7fff_fffe);
        default: ticks = WINDOW_RESET;
      endcase
      write_window(ticks);
      repeat (340) send_random_item();
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want_v, got_v, $realtime);
  endtask

  // receiver: stall in segments of changing character, or hold off when asked
  initial begin : sink_pattern
    int seg_left;
    int mode;
    int tick;
    seg_left = 0;
    mode     = 0;
    tick     = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(4, 60);
      end
      seg_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ((tick % 6) < 2);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d allowed %0b at %0t", status, allowed,
                   $realtime);
      end else begin
        want = pending_verdicts.pop_front();
        if (status !== want.status) flag_mismatch("status", want.status, status);
        if (allowed !== want.allowed) flag_mismatch("allowed", want.allowed, allowed);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("per_client_sliding_log_rate_limiter regression: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : main_flow
    foreach (used_m[k]) begin
      used_m[k] = 1'b0;
      fill_m[k] = 0;
      head_m[k] = 0;
      last_m[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_registration_and_admission();
    test_window_bounds();
    test_table_full();
    test_output_backpressure();
    test_drain_then_send();
    test_random_traffic();
    wait_drained();
    repeat (CLIENTS + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("per_client_sliding_log_rate_limiter regression: pass");
    end else begin
      $display("per_client_sliding_log_rate_limiter regression: fail");
    end
    $finish;
  end

endmodule
